>>> hw/rtl/ssws_pkg.sv
`timescale 1ns / 1ps
package ssws_pkg;

	localparam int COIN_W = 16;
	localparam int SUM_W  = 6;
	localparam int WORD_W = 64;

	typedef struct packed {
		logic [COIN_W-1:0] coin_value;
		logic              last_coin;
	} coin_in_t;

	typedef struct packed {
		logic              reachable;
		logic              has_coin;
		logic [COIN_W-1:0] coin_out;
		logic              overflow;
		logic              last_result;
	} result_t;

endpackage

>>> hw/rtl/subset_sum_with_selection.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Beat
// item      in         start & !busy              coin_in_t (coin_value, last_coin)
// config    in         cfg_we                     cfg_wdata = target_sum
// result    out        res_valid (one cycle)      result_t
//
// An unmarked coin leaves busy low and, if there is room, has one shift-OR of the
// reachability row written to the row memory. After a marked coin the block is busy
// through a check state, S backward steps (at most N stored coins) of a memory read
// and a compare, the header state, then a pop and an emit state for each coin result.
// Reset sets the row register to the sum-zero row and clears counts and flags; the memories need no clearing.
// The receiver cannot stall; every result is taken in the cycle it is shown.
module subset_sum_with_selection import ssws_pkg::*; #(
	parameter int MAX_COINS = 32,
	parameter int MAX_SUM   = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  coin_in_t             item,
	input  logic                 cfg_we,
	input  logic [SUM_W-1:0]     cfg_wdata,
	output logic                 res_valid,
	output result_t              res
);

	localparam int ROW_W = MAX_SUM + 1;
	localparam int CNT_W = $clog2(MAX_COINS + 1);
	localparam int IDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_STEP,
		ST_HEAD,
		ST_POP,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [SUM_W-1:0]   target_q;
	logic [ROW_W-1:0]   cur_row_q;
	logic [ROW_W-1:0]   hi_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   sp_q;
	logic [SUM_W-1:0]   j_q;
	logic               overflow_q;
	logic               reach_q;
	logic               lo_zero_q;
	logic               res_valid_q;
	result_t            res_q;

	logic [ROW_W-1:0]   reach_mem [MAX_COINS];
	logic [COIN_W-1:0]  coin_mem [MAX_COINS];
	logic [COIN_W-1:0]  chosen_mem [MAX_COINS];
	logic [ROW_W-1:0]   rd_row_q;
	logic [COIN_W-1:0]  rd_coin_q;
	logic [COIN_W-1:0]  pop_coin_q;

	logic               accept;
	logic               room;
	logic               fits;
	logic [ROW_W-1:0]   grown;
	logic [ROW_W-1:0]   lo_row;
	logic [WORD_W-1:0]  cur_ext;
	logic [WORD_W-1:0]  hi_ext;
	logic [WORD_W-1:0]  lo_ext;
	logic               take;
	logic [SUM_W-1:0]   j_next;
	logic [CNT_W-1:0]   i_next;
	logic [IDX_W-1:0]   row_rd_addr;
	logic [IDX_W-1:0]   coin_rd_addr;
	logic [IDX_W-1:0]   pop_addr;
	logic               reach_now;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign room      = (count_q < CNT_W'(MAX_COINS));
	assign fits      = (item.coin_value <= COIN_W'(MAX_SUM));
	assign grown     = cur_row_q | (fits ? (cur_row_q << item.coin_value[SUM_W-1:0])
	                                     : '0);
	assign lo_row    = lo_zero_q ? ROW_W'(1) : rd_row_q;
	assign cur_ext   = WORD_W'(cur_row_q);
	assign hi_ext    = WORD_W'(hi_q);
	assign lo_ext    = WORD_W'(lo_row);
	assign take      = hi_ext[j_q] && !lo_ext[j_q];
	assign j_next    = !take ? j_q
	                 : (rd_coin_q <= COIN_W'(j_q)) ? (j_q - rd_coin_q[SUM_W-1:0])
	                 : '0;
	assign i_next    = i_q - CNT_W'(1);
	assign row_rd_addr  = IDX_W'(i_q - CNT_W'(2));
	assign coin_rd_addr = IDX_W'(i_q - CNT_W'(1));
	assign pop_addr     = IDX_W'(sp_q - CNT_W'(1));
	assign reach_now = (target_q <= SUM_W'(MAX_SUM)) && cur_ext[target_q];

	always_ff @(posedge clk) begin
		if (accept && room) begin
			reach_mem[count_q[IDX_W-1:0]] <= grown;
			coin_mem[count_q[IDX_W-1:0]]  <= item.coin_value;
		end
		if (state_q == ST_READ) begin
			rd_row_q  <= reach_mem[row_rd_addr];
			rd_coin_q <= coin_mem[coin_rd_addr];
		end
		if (state_q == ST_STEP && take) begin
			chosen_mem[sp_q[IDX_W-1:0]] <= rd_coin_q;
		end
		if (state_q == ST_POP) begin
			pop_coin_q <= chosen_mem[pop_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_row_q   <= ROW_W'(1);
			hi_q        <= '0;
			count_q     <= '0;
			i_q         <= '0;
			sp_q        <= '0;
			j_q         <= '0;
			overflow_q  <= 1'b0;
			reach_q     <= 1'b0;
			lo_zero_q   <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) begin
							cur_row_q <= grown;
							count_q   <= count_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (item.last_coin) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					reach_q <= reach_now;
					i_q     <= count_q;
					j_q     <= target_q;
					hi_q    <= cur_row_q;
					sp_q    <= '0;
					if (reach_now && count_q != '0 && target_q != '0) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_HEAD;
					end
				end
				ST_READ: begin
					lo_zero_q <= (i_q == CNT_W'(1));
					state_q   <= ST_STEP;
				end
				ST_STEP: begin
					hi_q <= lo_row;
					i_q  <= i_next;
					j_q  <= j_next;
					if (take) begin
						sp_q <= sp_q + CNT_W'(1);
					end
					if (i_next != '0 && j_next != '0) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					res_valid_q       <= 1'b1;
					res_q.reachable   <= reach_q;
					res_q.has_coin    <= 1'b0;
					res_q.coin_out    <= '0;
					res_q.overflow    <= overflow_q;
					res_q.last_result <= (sp_q == '0);
					if (sp_q == '0) begin
						cur_row_q  <= ROW_W'(1);
						count_q    <= '0;
						overflow_q <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					sp_q    <= sp_q - CNT_W'(1);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					res_valid_q       <= 1'b1;
					res_q.reachable   <= 1'b1;
					res_q.has_coin    <= 1'b1;
					res_q.coin_out    <= pop_coin_q;
					res_q.overflow    <= overflow_q;
					res_q.last_result <= (sp_q == '0);
					if (sp_q == '0) begin
						cur_row_q  <= ROW_W'(1);
						count_q    <= '0;
						overflow_q <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_POP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last_result |=> !res_valid)
		else $error("result after last beat of a run");

	a_plain_coin_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !item.last_coin |=> !busy)
		else $error("unmarked coin left the block busy");

	a_coin_implies_reach: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.has_coin |-> res.reachable)
		else $error("coin emitted for unreachable target");

	a_step_row_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP |-> i_q != '0 && i_q <= count_q)
		else $error("walk stepped outside stored rows");

endmodule

>>> tb/subset_sum_with_selection_tb.sv
`timescale 1ns / 1ps
module subset_sum_with_selection_tb;
	import ssws_pkg::*;

	localparam int MAX_COINS  = 32;
	localparam int MAX_SUM    = 63;
	localparam int QUIET_MAX  = 5000;
	localparam int SET_ITEMS  = 10;

	class coin_book;
		logic [WORD_W-1:0] sums_after [MAX_COINS+1];
		logic [COIN_W-1:0] coins [MAX_COINS];
		int unsigned       n_coins;
		bit                dropped;
		logic [SUM_W-1:0]  target;
		result_t           pending [$];
		int                errors;

		function new();
			target = '0;
			errors = 0;
			clear_set();
		endfunction

		function void clear_set();
			foreach (sums_after[i])
				sums_after[i] = '0;
			sums_after[0] = WORD_W'(1);
			n_coins = 0;
			dropped = 0;
		endfunction

		function void take_coin(coin_in_t beat);
			logic [WORD_W-1:0] grown;
			logic [COIN_W-1:0] picked [$];
			int i;
			int j;
			bit hit;
			result_t r;
			if (n_coins < MAX_COINS) begin
				grown = sums_after[n_coins];
				if (beat.coin_value <= MAX_SUM)
					grown |= sums_after[n_coins] << beat.coin_value;
				coins[n_coins] = beat.coin_value;
				sums_after[n_coins+1] = grown;
				n_coins++;
			end else begin
				dropped = 1;
			end
			if (!beat.last_coin)
				return;
			hit = (target <= MAX_SUM) && sums_after[n_coins][target];
			if (hit) begin
				i = n_coins;
				j = target;
				while (i > 0 && j > 0) begin
					if (sums_after[i][j] && !sums_after[i-1][j]) begin
						picked = {picked, coins[i-1]};
						j = (coins[i-1] <= j) ? j - coins[i-1] : 0;
					end
					i--;
				end
			end
			r.reachable   = hit;
			r.has_coin    = 1'b0;
			r.coin_out    = '0;
			r.overflow    = dropped;
			r.last_result = (picked.size() == 0);
			pending = {pending, r};
			for (i = picked.size() - 1; i >= 0; i--) begin
				r.reachable   = 1'b1;
				r.has_coin    = 1'b1;
				r.coin_out    = picked[i];
				r.overflow    = dropped;
				r.last_result = (i == 0);
				pending = {pending, r};
			end
			clear_set();
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t ns %s mismatch: expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$display("%0t ns unexpected result: expected none, actual %0h", $time, got);
				errors++;
				return;
			end
			want = pending[0];
			pending.delete(0);
			compare_field("reachable", 32'(want.reachable), 32'(got.reachable));
			compare_field("has_coin", 32'(want.has_coin), 32'(got.has_coin));
			compare_field("coin_out", 32'(want.coin_out), 32'(got.coin_out));
			compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
			compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	coin_in_t         item = '0;
	logic             cfg_we = 1'b0;
	logic [SUM_W-1:0] cfg_wdata = '0;
	logic             res_valid;
	result_t          res;

	coin_book book;

	subset_sum_with_selection #(
		.MAX_COINS (MAX_COINS),
		.MAX_SUM   (MAX_SUM)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_valid (res_valid),
		.res       (res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid)
				book.match_result(res);
			if (start && !busy)
				book.take_coin(item);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_MAX) begin
			@(posedge clk);
			if ((arst_n && start && !busy) || res_valid)
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_coin(input logic [COIN_W-1:0] value, input logic last, input int idle_pct);
		start <= 1'b1;
		item  <= {value, last};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// drain the set in flight before touching the register
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (busy || book.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_target(input logic [SUM_W-1:0] value);
		drain();
		repeat (8)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		book.target = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int p;
		int k;
		int sent;
		int len;
		int pick;
		int idle_pct;
		logic [COIN_W-1:0] value;
		logic [SUM_W-1:0]  goal;

		book = new();
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_target(6'd0);
		send_coin(16'd5, 1'b1, 0);

		write_target(6'd63);
		send_coin(16'd0, 1'b0, 0);
		send_coin(16'hFFFF, 1'b0, 0);
		send_coin(16'd64, 1'b0, 0);
		send_coin(16'd63, 1'b1, 0);
		send_coin(16'd1, 1'b0, 0);
		send_coin(16'd2, 1'b1, 0);

		write_target(6'd10);
		send_coin(16'd3, 1'b0, 0);
		send_coin(16'd7, 1'b0, 0);
		send_coin(16'd10, 1'b0, 0);
		send_coin(16'd5, 1'b0, 0);
		send_coin(16'd5, 1'b1, 0);
		send_coin(16'd0, 1'b1, 0);
		send_coin(16'h8000, 1'b0, 0);
		send_coin(16'h5555, 1'b0, 0);
		send_coin(16'hAAAA, 1'b1, 0);

		for (p = 0; p < 6; p++) begin
			case (p)
				0: goal = 6'd63;
				1: goal = SUM_W'($urandom_range(1, 62));
				2: goal = 6'd0;
				3: goal = SUM_W'($urandom_range(1, 40));
				4: goal = SUM_W'($urandom_range(20, 62));
				default: goal = 6'd63;
			endcase
			idle_pct = (p < 2) ? 38 : (p < 4) ? 71 : 0;
			write_target(goal);
			sent = 0;
			while (sent < SET_ITEMS) begin
				if (p == 1 && sent == 0)
					len = 34;
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(9, 36);
				else
					len = $urandom_range(1, 8);
				for (k = 0; k < len; k++) begin
					pick = $urandom_range(0, 19);
					if (pick < 14)
						value = COIN_W'($urandom_range(0, 24));
					else if (pick < 17)
						value = COIN_W'($urandom_range(25, 63));
					else
						value = COIN_W'($urandom());
					send_coin(value, k == len - 1, idle_pct);
				end
				sent += len;
			end
		end

		drain();
		repeat (150)
			@(posedge clk);
		if (book.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
